### rtl/ctst_pkg.sv
// Shared types and constants for the compass tape tick generator.
// No dependencies; imported by ctst_alu, ctst_cfg_regs and the top level.
package ctst_pkg;

  // Shared multiply / divide unit operand width and its bit counter width
  localparam int unsigned ALU_W  = 26;
  localparam int unsigned ALU_CW = $clog2(ALU_W + 1);

  // Signed working width for pixel positions and scale values
  localparam int unsigned POS_W = 27;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Fixed drawing gaps in pixels
  localparam int unsigned INDEX_GAP = 2;
  localparam int unsigned LABEL_GAP = 3;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN    = 3'd0,
    REG_Y_ORIGIN    = 3'd1,
    REG_TAPE_LENGTH = 3'd2,
    REG_MINOR_STEP  = 3'd3,
    REG_MAJOR_STEP  = 3'd4,
    REG_PPU_Q16     = 3'd5,
    REG_ORIENT      = 3'd6,
    REG_FONT_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PITCH,
    ST_BASE,
    ST_DPIX,
    ST_HTICK,
    ST_HPIX,
    ST_HVAL,
    ST_XV,
    ST_NEGMOD,
    ST_DPADJ,
    ST_SNAP,
    ST_IDXOUT,
    ST_TWRAP,
    ST_TMAJ,
    ST_TOUT
  } st_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ALU_W-1:0]  a;      // multiplicand or divisor
    logic [ALU_W-1:0]  b;      // multiplier or dividend, below 2**nbits
    logic [ALU_CW-1:0] nbits;  // significant bits of b, 1..ALU_W
  } alu_cmd_t;

  // Effective configuration; zero steps already replaced by one
  typedef struct packed {
    logic [11:0] x_origin;
    logic [11:0] y_origin;
    logic [9:0]  tape_length;
    logic [15:0] minor_step;
    logic [15:0] major_step;
    logic [23:0] ppu_q16;
    logic        orient_right;
    logic [7:0]  font_height;
  } cfg_t;

endpackage

### rtl/ctst_alu.sv
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on ctst_pkg.
module ctst_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  ctst_pkg::alu_cmd_t            cmd_i,
  output logic                          done_o,
  output logic [2*ctst_pkg::ALU_W-1:0]  acc_o,
  output logic [ctst_pkg::ALU_W-1:0]    quot_o
);
  import ctst_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ALU_CW-1:0]    cnt_q, cnt_d;
  alu_op_e              op_q, op_d;
  logic [ALU_W-1:0]     a_q, a_d;
  logic [ALU_W-1:0]     sh_q, sh_d;
  logic [2*ALU_W-1:0]   acc_q, acc_d;

  logic                 bit_in;
  logic [ALU_W:0]       rem_n;
  logic [ALU_W:0]       rem_sub;
  logic                 ge;
  logic [2*ALU_W-1:0]   mul_n;
  logic [ALU_CW-1:0]    shamt;

  always_comb begin
    bit_in  = sh_q[ALU_W-1];
    rem_n   = {acc_q[ALU_W-1:0], bit_in};
    rem_sub = rem_n - {1'b0, a_q};
    ge      = (rem_n >= {1'b0, a_q});
    mul_n   = {acc_q[2*ALU_W-2:0], 1'b0} + (bit_in ? (2*ALU_W)'(a_q) : '0);
    shamt   = ALU_CW'(ALU_W) - cmd_i.nbits;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.nbits;
      op_d   = cmd_i.op;
      a_d    = cmd_i.a;
      sh_d   = cmd_i.b << shamt;   // left-align the significant bits
      acc_d  = '0;
    end else if (busy_q) begin
      unique case (op_q)
        ALU_MUL: begin
          acc_d = mul_n;
          sh_d  = {sh_q[ALU_W-2:0], 1'b0};
        end
        ALU_DIV: begin
          acc_d = (2*ALU_W)'(ge ? rem_sub[ALU_W-1:0] : rem_n[ALU_W-1:0]);
          sh_d  = {sh_q[ALU_W-2:0], ge};   // quotient bits enter at the bottom
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ALU_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;   // product, or remainder in the low bits
  assign quot_o = sh_q;

endmodule

### rtl/ctst_cfg_regs.sv
// Configuration register file with reset values and zero-step fixup.
// Depends on ctst_pkg.
module ctst_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ctst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ctst_pkg::cfg_t                 cfg_o
);
  import ctst_pkg::*;

  cfg_t raw_q, raw_d;

  always_comb begin
    raw_d = raw_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_ORIGIN:    raw_d.x_origin     = cfg_wdata_i[11:0];
        REG_Y_ORIGIN:    raw_d.y_origin     = cfg_wdata_i[11:0];
        REG_TAPE_LENGTH: raw_d.tape_length  = cfg_wdata_i[9:0];
        REG_MINOR_STEP:  raw_d.minor_step   = cfg_wdata_i[15:0];
        REG_MAJOR_STEP:  raw_d.major_step   = cfg_wdata_i[15:0];
        REG_PPU_Q16:     raw_d.ppu_q16      = cfg_wdata_i[23:0];
        REG_ORIENT:      raw_d.orient_right = cfg_wdata_i[0];
        REG_FONT_HEIGHT: raw_d.font_height  = cfg_wdata_i[7:0];
        default:         raw_d = raw_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q.x_origin     <= 12'd0;
      raw_q.y_origin     <= 12'd0;
      raw_q.tape_length  <= 10'd200;
      raw_q.minor_step   <= 16'd500;
      raw_q.major_step   <= 16'd1000;
      raw_q.ppu_q16      <= 24'd65536;
      raw_q.orient_right <= 1'b0;
      raw_q.font_height  <= 8'd10;
    end else begin
      raw_q <= raw_d;
    end
  end

  // A zero step behaves as a step of one
  always_comb begin
    cfg_o = raw_q;
    if (raw_q.minor_step == 16'd0) cfg_o.minor_step = 16'd1;
    if (raw_q.major_step == 16'd0) cfg_o.major_step = 16'd1;
  end

endmodule

### rtl/compass_tape_scale_ticks.sv
// Compass tape tick generator: one heading in, up to MAX_SEGMENTS line segments out.
// Setup runs the one-bit-per-cycle shared mul/div unit for pitch, base, offset, half-tape
// and snap (plus a full modulo when the start value needs one), then again for each tick.
// Throughput: one heading at a time; in_ready_o is high only while the sequencer idles.
// Reset (rst_ni, async, active low) idles the sequencer, drops out_valid_o and loads
// the register defaults. Depends on ctst_pkg, ctst_alu, ctst_cfg_regs.
module compass_tape_scale_ticks #(
  parameter int unsigned MAX_SEGMENTS   = 32,
  parameter int unsigned FULL_CIRCLE    = 36000,
  parameter int unsigned INDEX_MARK_LEN = 8,
  parameter int unsigned MAJOR_TICK_LEN = 8,
  parameter int unsigned MINOR_TICK_LEN = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [ctst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // heading beats
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [23:0]                     heading_q8_i,
  // segment beats
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [13:0]              x_start_o,
  output logic signed [13:0]              y_start_o,
  output logic signed [13:0]              x_end_o,
  output logic signed [13:0]              y_end_o,
  output logic                            is_index_mark_o,
  output logic                            is_major_o,
  output logic [15:0]                     tick_value_o,
  output logic signed [13:0]              label_baseline_y_o,
  output logic                            last_segment_o
);
  import ctst_pkg::*;

  localparam int unsigned SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [15:0] FC16 = 16'(FULL_CIRCLE);
  localparam logic signed [POS_W-1:0] FC_S = POS_W'(FULL_CIRCLE);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  ctst_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------------------
  // Shared multiply / divide unit
  // ---------------------------------------------------------------------------
  alu_cmd_t           alu_cmd;
  logic               alu_start;
  logic               alu_done;
  logic [2*ALU_W-1:0] alu_acc;
  logic [ALU_W-1:0]   alu_quot;
  logic               uses_alu;
  logic               op_run_q, op_run_d;

  ctst_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .cmd_i   (alu_cmd),
    .done_o  (alu_done),
    .acc_o   (alu_acc),
    .quot_o  (alu_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers
  // ---------------------------------------------------------------------------
  st_e state_q, state_d;

  logic [23:0]              hq_q, hq_d;          // latched heading
  logic [24:0]              pitch_q, pitch_d;    // tick pitch in pixels, never 0
  logic [15:0]              base_q, base_d;      // heading snapped down to minor step
  logic [23:0]              frac_q, frac_d;      // leftover of the heading, Q.8
  logic [24:0]              dpix_q, dpix_d;      // pixel offset of that leftover
  logic [9:0]               hticks_q, hticks_d;  // ticks left of the center
  logic [9:0]               hpix_q, hpix_d;      // their span in pixels
  logic signed [POS_W-1:0]  x_q, x_d;            // x of the next tick
  logic signed [POS_W-1:0]  v_q, v_d;            // value of the next tick
  logic                     maj_q, maj_d;
  logic [SEG_CW-1:0]        nseg_q, nseg_d;      // segments emitted so far

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [13:0] out_xs_q, out_ys_q, out_xe_q, out_ye_q, out_lab_q;
  logic [13:0] out_xs_d, out_ys_d, out_xe_d, out_ye_d, out_lab_d;
  logic        out_idx_q, out_idx_d, out_maj_q, out_maj_d, out_last_q, out_last_d;
  logic [15:0] out_val_q, out_val_d;
  logic        out_free;
  logic        out_load;

  // ---------------------------------------------------------------------------
  // Geometry helpers
  // ---------------------------------------------------------------------------
  logic [12:0]              xref;        // tape center x
  logic [12:0]              top;         // right end x, exclusive
  logic signed [POS_W-1:0]  xref_s, top_s, pitch_s, minor_s, x_next_s;
  logic signed [POS_W-1:0]  neg_v, vm1;
  logic [15:0]              rem16;
  logic [24:0]              pitch_raw;
  logic                     last_idx, last_tick;
  logic [SEG_CW:0]          nseg_inc;
  logic [13:0]              yo14, iy1, iy2, tick_w, tick_ye, lab;

  always_comb begin
    xref      = 13'(cfg.x_origin) + 13'((11'(cfg.tape_length) + 11'd1) >> 1);
    top       = 13'(cfg.x_origin) + 13'(cfg.tape_length);
    xref_s    = POS_W'(xref);
    top_s     = POS_W'(top);
    pitch_s   = POS_W'(pitch_q);
    minor_s   = POS_W'(cfg.minor_step);
    x_next_s  = x_q + pitch_s;
    neg_v     = -v_q;
    vm1       = v_q - POS_W'(1);
    rem16     = alu_acc[15:0];
    pitch_raw = 25'(alu_acc[40:16]) + 25'(alu_acc[15]);
    nseg_inc  = (SEG_CW+1)'(nseg_q) + (SEG_CW+1)'(1);
    // the index mark is last when no tick falls inside the tape
    last_idx  = !(x_q < top_s);
    last_tick = !(x_next_s < top_s) || (nseg_inc >= (SEG_CW+1)'(MAX_SEGMENTS));

    // y geometry, all in 14-bit wraparound
    yo14   = 14'(cfg.y_origin);
    iy1    = cfg.orient_right ? yo14 - 14'(INDEX_GAP) : yo14 + 14'(INDEX_GAP);
    iy2    = cfg.orient_right ? iy1 - 14'(INDEX_MARK_LEN) : iy1 + 14'(INDEX_MARK_LEN);
    tick_w = maj_q ? 14'(MAJOR_TICK_LEN) : 14'(MINOR_TICK_LEN);
    tick_ye = cfg.orient_right ? yo14 + tick_w : yo14 - tick_w;
    if (!maj_q) begin
      lab = '0;
    end else if (cfg.orient_right) begin
      lab = tick_ye + 14'(LABEL_GAP) + 14'(cfg.font_height);
    end else begin
      lab = tick_ye - 14'(LABEL_GAP);
    end
  end

  // ---------------------------------------------------------------------------
  // Unit command per state
  // ---------------------------------------------------------------------------
  always_comb begin
    alu_cmd.op    = ALU_MUL;
    alu_cmd.a     = '0;
    alu_cmd.b     = '0;
    alu_cmd.nbits = ALU_CW'(1);
    uses_alu      = 1'b0;
    unique case (state_q)
      ST_PITCH: begin
        // minor_step * pixels_per_unit
        uses_alu      = 1'b1;
        alu_cmd.a     = ALU_W'(cfg.ppu_q16);
        alu_cmd.b     = ALU_W'(cfg.minor_step);
        alu_cmd.nbits = ALU_CW'(16);
      end
      ST_BASE: begin
        // integer heading mod minor_step
        uses_alu      = 1'b1;
        alu_cmd.op    = ALU_DIV;
        alu_cmd.a     = ALU_W'(cfg.minor_step);
        alu_cmd.b     = ALU_W'(hq_q[23:8]);
        alu_cmd.nbits = ALU_CW'(16);
      end
      ST_DPIX: begin
        uses_alu      = 1'b1;
        alu_cmd.a     = ALU_W'(cfg.ppu_q16);
        alu_cmd.b     = ALU_W'(frac_q);
        alu_cmd.nbits = ALU_CW'(24);
      end
      ST_HTICK: begin
        // tape_length / (2 * pitch)
        uses_alu      = 1'b1;
        alu_cmd.op    = ALU_DIV;
        alu_cmd.a     = {pitch_q, 1'b0};
        alu_cmd.b     = ALU_W'(cfg.tape_length);
        alu_cmd.nbits = ALU_CW'(10);
      end
      ST_HPIX: begin
        uses_alu      = 1'b1;
        alu_cmd.a     = ALU_W'(pitch_q);
        alu_cmd.b     = ALU_W'(hticks_q);
        alu_cmd.nbits = ALU_CW'(10);
      end
      ST_HVAL: begin
        uses_alu      = 1'b1;
        alu_cmd.a     = ALU_W'(cfg.minor_step);
        alu_cmd.b     = ALU_W'(hticks_q);
        alu_cmd.nbits = ALU_CW'(10);
      end
      ST_NEGMOD: begin
        // start value still negative after one added circle
        uses_alu      = (v_q < 0);
        alu_cmd.op    = ALU_DIV;
        alu_cmd.a     = ALU_W'(FC16);
        alu_cmd.b     = neg_v[ALU_W-1:0];
        alu_cmd.nbits = ALU_CW'(ALU_W);
      end
      ST_SNAP: begin
        uses_alu      = 1'b1;
        alu_cmd.op    = ALU_DIV;
        alu_cmd.a     = ALU_W'(cfg.minor_step);
        alu_cmd.b     = ALU_W'(v_q[17:0]);
        alu_cmd.nbits = ALU_CW'(18);
      end
      ST_TWRAP: begin
        // value past one circle folds into 1..FULL_CIRCLE
        uses_alu      = (v_q > FC_S);
        alu_cmd.op    = ALU_DIV;
        alu_cmd.a     = ALU_W'(FC16);
        alu_cmd.b     = ALU_W'(vm1[17:0]);
        alu_cmd.nbits = ALU_CW'(18);
      end
      ST_TMAJ: begin
        uses_alu      = 1'b1;
        alu_cmd.op    = ALU_DIV;
        alu_cmd.a     = ALU_W'(cfg.major_step);
        alu_cmd.b     = ALU_W'(v_q[15:0]);
        alu_cmd.nbits = ALU_CW'(16);
      end
      default: begin
        uses_alu = 1'b0;
      end
    endcase
  end

  assign alu_start = uses_alu && !op_run_q;
  assign op_run_d  = alu_start ? 1'b1 : (alu_done ? 1'b0 : op_run_q);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PITCH;
      ST_PITCH:  if (alu_done) state_d = ST_BASE;
      ST_BASE:   if (alu_done) state_d = ST_DPIX;
      ST_DPIX:   if (alu_done) state_d = ST_HTICK;
      ST_HTICK:  if (alu_done) state_d = ST_HPIX;
      ST_HPIX:   if (alu_done) state_d = ST_HVAL;
      ST_HVAL:   if (alu_done) state_d = ST_XV;
      ST_XV:     state_d = ST_NEGMOD;
      ST_NEGMOD: if (!uses_alu || alu_done) state_d = ST_DPADJ;
      ST_DPADJ:  state_d = ST_SNAP;
      ST_SNAP:   if (alu_done) state_d = ST_IDXOUT;
      ST_IDXOUT: if (out_free) state_d = last_idx ? ST_IDLE : ST_TWRAP;
      ST_TWRAP:  if (!uses_alu || alu_done) state_d = ST_TMAJ;
      ST_TMAJ:   if (alu_done) state_d = ST_TOUT;
      ST_TOUT:   if (out_free) state_d = last_tick ? ST_IDLE : ST_TWRAP;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and output register loads
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    hq_d      = hq_q;
    pitch_d   = pitch_q;
    base_d    = base_q;
    frac_d    = frac_q;
    dpix_d    = dpix_q;
    hticks_d  = hticks_q;
    hpix_d    = hpix_q;
    x_d       = x_q;
    v_d       = v_q;
    maj_d     = maj_q;
    nseg_d    = nseg_q;
    out_load  = 1'b0;
    out_xs_d  = out_xs_q;
    out_ys_d  = out_ys_q;
    out_xe_d  = out_xe_q;
    out_ye_d  = out_ye_q;
    out_idx_d = out_idx_q;
    out_maj_d = out_maj_q;
    out_val_d = out_val_q;
    out_lab_d = out_lab_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) hq_d = heading_q8_i;
      end
      ST_PITCH: begin
        // round half up; a pitch below half a pixel counts as one
        if (alu_done) pitch_d = (pitch_raw == 25'd0) ? 25'd1 : pitch_raw;
      end
      ST_BASE: begin
        if (alu_done) begin
          base_d = hq_q[23:8] - rem16;
          frac_d = {rem16, hq_q[7:0]};
        end
      end
      ST_DPIX: begin
        if (alu_done) dpix_d = 25'(alu_acc[48:24]) + 25'(alu_acc[23]);
      end
      ST_HTICK: begin
        if (alu_done) hticks_d = alu_quot[9:0];
      end
      ST_HPIX: begin
        // hticks * pitch never exceeds half the tape
        if (alu_done) hpix_d = alu_acc[9:0];
      end
      ST_HVAL: begin
        if (alu_done) v_d = POS_W'(base_q) - POS_W'(alu_acc[ALU_W-1:0]);
      end
      ST_XV: begin
        x_d = xref_s - POS_W'(hpix_q) - POS_W'(dpix_q);
        if (v_q <= 0) v_d = v_q + FC_S;
      end
      ST_NEGMOD: begin
        if (alu_done) v_d = (rem16 == 16'd0) ? '0 : FC_S - POS_W'(rem16);
      end
      ST_DPADJ: begin
        // a nonzero offset moves the first tick one pitch to the right
        if (dpix_q != 25'd0) begin
          x_d = x_q + pitch_s;
          v_d = v_q + minor_s;
        end
      end
      ST_SNAP: begin
        if (alu_done) v_d = v_q - POS_W'(rem16);
      end
      ST_IDXOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_xs_d   = 14'(xref);
          out_ys_d   = iy1;
          out_xe_d   = 14'(xref);
          out_ye_d   = iy2;
          out_idx_d  = 1'b1;
          out_maj_d  = 1'b0;
          out_val_d  = '0;
          out_lab_d  = '0;
          out_last_d = last_idx;
          nseg_d     = SEG_CW'(1);
        end
      end
      ST_TWRAP: begin
        if (alu_done) v_d = POS_W'(rem16) + POS_W'(1);
      end
      ST_TMAJ: begin
        if (alu_done) maj_d = (alu_acc[ALU_W-1:0] == '0);
      end
      ST_TOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_xs_d   = x_q[13:0];
          out_ys_d   = yo14;
          out_xe_d   = x_q[13:0];
          out_ye_d   = tick_ye;
          out_idx_d  = 1'b0;
          out_maj_d  = maj_q;
          out_val_d  = v_q[15:0];
          out_lab_d  = lab;
          out_last_d = last_tick;
          x_d        = x_next_s;
          v_d        = v_q + minor_s;
          nseg_d     = nseg_inc[SEG_CW-1:0];
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_run_q    <= 1'b0;
      out_valid_q <= 1'b0;
      nseg_q      <= '0;
    end else begin
      state_q     <= state_d;
      op_run_q    <= op_run_d;
      out_valid_q <= out_valid_d;
      nseg_q      <= nseg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hq_q       <= hq_d;
    pitch_q    <= pitch_d;
    base_q     <= base_d;
    frac_q     <= frac_d;
    dpix_q     <= dpix_d;
    hticks_q   <= hticks_d;
    hpix_q     <= hpix_d;
    x_q        <= x_d;
    v_q        <= v_d;
    maj_q      <= maj_d;
    out_xs_q   <= out_xs_d;
    out_ys_q   <= out_ys_d;
    out_xe_q   <= out_xe_d;
    out_ye_q   <= out_ye_d;
    out_idx_q  <= out_idx_d;
    out_maj_q  <= out_maj_d;
    out_val_q  <= out_val_d;
    out_lab_q  <= out_lab_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign x_start_o          = out_xs_q;
  assign y_start_o          = out_ys_q;
  assign x_end_o            = out_xe_q;
  assign y_end_o            = out_ye_q;
  assign is_index_mark_o    = out_idx_q;
  assign is_major_o         = out_maj_q;
  assign tick_value_o       = out_val_q;
  assign label_baseline_y_o = out_lab_q;
  assign last_segment_o     = out_last_q;

endmodule

### tb/sv/compass_tape_scale_ticks_chk.sv
// Scoreboard for the compass tape tick generator: tracks register writes, predicts
// the segment beats of every accepted heading and compares them with the output.
// Depends on ctst_pkg (cfg_t, cfg_reg_e, drawing gaps).
module compass_tape_scale_ticks_chk #(
  parameter int MAX_SEGMENTS   = 32,
  parameter int FULL_CIRCLE    = 36000,
  parameter int INDEX_MARK_LEN = 8,
  parameter int MAJOR_TICK_LEN = 8,
  parameter int MINOR_TICK_LEN = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ctst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [23:0]                     heading_q8_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [13:0]              x_start_i,
  input  logic signed [13:0]              y_start_i,
  input  logic signed [13:0]              x_end_i,
  input  logic signed [13:0]              y_end_i,
  input  logic                            is_index_mark_i,
  input  logic                            is_major_i,
  input  logic [15:0]                     tick_value_i,
  input  logic signed [13:0]              label_baseline_y_i,
  input  logic                            last_segment_i,
  input  logic                            done_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctst_pkg::*;

  typedef struct packed {
    logic [13:0] xs;
    logic [13:0] ys;
    logic [13:0] xe;
    logic [13:0] ye;
    logic        index_mark;
    logic        major;
    logic [15:0] value;
    logic [13:0] label;
    logic        last;
  } tape_seg_t;

  cfg_t        tape_cfg;
  tape_seg_t   seg_expect_q[$];
  tape_seg_t   got, want;
  int unsigned err_cnt = 0;
  int unsigned seg_cnt = 0;
  bit          done_seen = 0;

  assign errors_o = err_cnt;

  task automatic note_mismatch(input string what, input logic [15:0] seen,
                               input logic [15:0] wanted);
    err_cnt++;
    if (err_cnt <= 40)
      $display("%0t ns: segment %0d: %s is %0h, wanted %0h", $time, seg_cnt, what,
               seen, wanted);
  endtask

  // Segments of the tape for one heading under the current register set
  function automatic void draw_tape(input logic [23:0] hdg);
    longint    minor, major, len, xo, yo, fc, hq, pitch, xref, top;
    longint    base, frac, dpix, hticks, x, v, w, ye, lab, iy1, iy2;
    bit        right, maj;
    int        n;
    tape_seg_t segs [MAX_SEGMENTS];
    minor = (tape_cfg.minor_step == 0) ? 1 : longint'(tape_cfg.minor_step);
    major = (tape_cfg.major_step == 0) ? 1 : longint'(tape_cfg.major_step);
    len   = longint'(tape_cfg.tape_length);
    xo    = longint'(tape_cfg.x_origin);
    yo    = longint'(tape_cfg.y_origin);
    fc    = FULL_CIRCLE;
    right = tape_cfg.orient_right;
    hq    = longint'(hdg);

    pitch = (minor * longint'(tape_cfg.ppu_q16) + 32768) >> 16;
    if (pitch == 0) pitch = 1;
    xref = xo + (len + 1) / 2;
    top  = xo + len;

    // heading split into whole minor steps and the leftover fraction (Q.8)
    base = (hq >> 8) / minor * minor;
    frac = hq - (base << 8);
    dpix = (frac * longint'(tape_cfg.ppu_q16) + 64'h80_0000) >> 24;

    hticks = len / (2 * pitch);
    x = xref - hticks * pitch - dpix;
    v = base - hticks * minor;
    if (v <= 0) v += fc;
    // very wide tapes can leave the start value below zero after one circle
    if (v < 0) v = (fc - ((-v) % fc)) % fc;
    if (dpix != 0) begin
      x += pitch;
      v += minor;
    end
    v = v / minor * minor;

    iy1 = right ? yo - longint'(INDEX_GAP) : yo + longint'(INDEX_GAP);
    iy2 = right ? iy1 - INDEX_MARK_LEN : iy1 + INDEX_MARK_LEN;
    segs[0] = '{xs: xref[13:0], ys: iy1[13:0], xe: xref[13:0], ye: iy2[13:0],
                index_mark: 1'b1, major: 1'b0, value: 16'd0, label: 14'd0, last: 1'b0};
    n = 1;

    while (x < top && n < MAX_SEGMENTS) begin
      if (v > fc) v = ((v - 1) % fc) + 1;
      maj = (v % major) == 0;
      w   = maj ? MAJOR_TICK_LEN : MINOR_TICK_LEN;
      ye  = right ? yo + w : yo - w;
      lab = 0;
      if (maj)
        lab = right ? ye + longint'(LABEL_GAP) + longint'(tape_cfg.font_height)
                    : ye - longint'(LABEL_GAP);
      segs[n] = '{xs: x[13:0], ys: yo[13:0], xe: x[13:0], ye: ye[13:0],
                  index_mark: 1'b0, major: maj, value: v[15:0], label: lab[13:0],
                  last: 1'b0};
      n++;
      x += pitch;
      v += minor;
    end

    segs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) seg_expect_q.push_back(segs[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_cfg.x_origin     = '0;
      tape_cfg.y_origin     = '0;
      tape_cfg.tape_length  = 10'd200;
      tape_cfg.minor_step   = 16'd500;
      tape_cfg.major_step   = 16'd1000;
      tape_cfg.ppu_q16      = 24'd65536;
      tape_cfg.orient_right = 1'b0;
      tape_cfg.font_height  = 8'd10;
      seg_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_X_ORIGIN:    tape_cfg.x_origin     = cfg_wdata_i[11:0];
          REG_Y_ORIGIN:    tape_cfg.y_origin     = cfg_wdata_i[11:0];
          REG_TAPE_LENGTH: tape_cfg.tape_length  = cfg_wdata_i[9:0];
          REG_MINOR_STEP:  tape_cfg.minor_step   = cfg_wdata_i[15:0];
          REG_MAJOR_STEP:  tape_cfg.major_step   = cfg_wdata_i[15:0];
          REG_PPU_Q16:     tape_cfg.ppu_q16      = cfg_wdata_i[23:0];
          REG_ORIENT:      tape_cfg.orient_right = cfg_wdata_i[0];
          REG_FONT_HEIGHT: tape_cfg.font_height  = cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) draw_tape(heading_q8_i);

      if (out_valid_i && out_ready_i) begin
        got = '{xs: x_start_i, ys: y_start_i, xe: x_end_i, ye: y_end_i,
                index_mark: is_index_mark_i, major: is_major_i, value: tick_value_i,
                label: label_baseline_y_i, last: last_segment_i};
        if (seg_expect_q.size() == 0) begin
          note_mismatch("unexpected beat", 16'd1, 16'd0);
        end else begin
          want = seg_expect_q.pop_front();
          if (got.xs !== want.xs) note_mismatch("x_start", got.xs, want.xs);
          if (got.ys !== want.ys) note_mismatch("y_start", got.ys, want.ys);
          if (got.xe !== want.xe) note_mismatch("x_end", got.xe, want.xe);
          if (got.ye !== want.ye) note_mismatch("y_end", got.ye, want.ye);
          if (got.index_mark !== want.index_mark)
            note_mismatch("is_index_mark", got.index_mark, want.index_mark);
          if (got.major !== want.major) note_mismatch("is_major", got.major, want.major);
          if (got.value !== want.value) note_mismatch("tick_value", got.value, want.value);
          if (got.label !== want.label)
            note_mismatch("label_baseline_y", got.label, want.label);
          if (got.last !== want.last) note_mismatch("last_segment", got.last, want.last);
        end
        seg_cnt++;
      end

      if (done_i && !done_seen) begin
        done_seen = 1;
        if (seg_expect_q.size() != 0)
          note_mismatch("segments never delivered", seg_expect_q.size(), 16'd0);
      end

      pending_o <= seg_expect_q.size();
    end
  end

endmodule

### tb/sv/compass_tape_scale_ticks_tb.sv
// Top of the compass tape tick generator bench: clock, reset, register setup,
// heading and back-pressure stimulus, and the final verdict.
// Depends on ctst_pkg, compass_tape_scale_ticks and compass_tape_scale_ticks_chk.
module compass_tape_scale_ticks_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctst_pkg::*;

  localparam int MAX_SEGMENTS   = 32;
  localparam int FULL_CIRCLE    = 36000;
  localparam int INDEX_MARK_LEN = 8;
  localparam int MAJOR_TICK_LEN = 8;
  localparam int MINOR_TICK_LEN = 4;
  localparam int HEADING_MAX    = 9216000;   // one full circle in Q.8

  localparam int RANDOM_HEADINGS = 420;
  // Time left after the last segment before a register write
  localparam int SETTLE_CYCLES   = 8;
  // Tail wait once nothing is outstanding; well past one full setup
  localparam int TAIL_CYCLES     = 300;
  // Receiver hold-off that fills the block and stalls the heading input
  localparam int HOLD_CYCLES     = 600;
  // Slowest run: up to 468 headings x 32 segments, each with its tick work and the longest
  // receiver stall, plus setup and sender gaps; take several times that.
  localparam int LIMIT_CYCLES    = 8_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic [23:0]           heading_q8_i = '0;
  logic                  out_ready_i  = 1'b0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic signed [13:0]    x_start_o, y_start_o, x_end_o, y_end_o;
  logic                  is_index_mark_o, is_major_o, last_segment_o;
  logic [15:0]           tick_value_o;
  logic signed [13:0]    label_baseline_y_o;

  logic                  done = 1'b0;
  int unsigned           pending;
  int unsigned           errors;

  // Stimulus knobs shared between the sender and receiver processes
  bit          quiet    = 1'b0;   // no idling on either side
  bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
  int unsigned cur_minor = 500;
  int unsigned headings_sent = 0;
  int unsigned cycle_cnt = 0;

  always #5 clk_i = ~clk_i;

  compass_tape_scale_ticks #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .FULL_CIRCLE   (FULL_CIRCLE),
    .INDEX_MARK_LEN(INDEX_MARK_LEN),
    .MAJOR_TICK_LEN(MAJOR_TICK_LEN),
    .MINOR_TICK_LEN(MINOR_TICK_LEN)
  ) dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .heading_q8_i,
    .out_valid_o, .out_ready_i,
    .x_start_o, .y_start_o, .x_end_o, .y_end_o,
    .is_index_mark_o, .is_major_o, .tick_value_o, .label_baseline_y_o, .last_segment_o
  );

  compass_tape_scale_ticks_chk #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .FULL_CIRCLE   (FULL_CIRCLE),
    .INDEX_MARK_LEN(INDEX_MARK_LEN),
    .MAJOR_TICK_LEN(MAJOR_TICK_LEN),
    .MINOR_TICK_LEN(MINOR_TICK_LEN)
  ) chk (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .heading_q8_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .x_start_i(x_start_o), .y_start_i(y_start_o), .x_end_i(x_end_o), .y_end_i(y_end_o),
    .is_index_mark_i(is_index_mark_o), .is_major_i(is_major_o),
    .tick_value_i(tick_value_o), .label_baseline_y_i(label_baseline_y_o),
    .last_segment_i(last_segment_o),
    .done_i(done), .pending_o(pending), .errors_o(errors)
  );

  // Idle length: mostly none or a few cycles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // One register write per clock; the write lands at the edge we wait for
  task automatic write_reg(input cfg_reg_e r, input int unsigned d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= d[CFG_DATA_W-1:0];
    @(posedge clk_i);
  endtask

  // Full register set; only called while the block is idle
  task automatic load_tape(input int unsigned xo, input int unsigned yo,
                           input int unsigned len, input int unsigned minor,
                           input int unsigned major, input int unsigned ppu,
                           input bit orient, input int unsigned font);
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_Y_ORIGIN, yo);
    write_reg(REG_TAPE_LENGTH, len);
    write_reg(REG_MINOR_STEP, minor);
    write_reg(REG_MAJOR_STEP, major);
    write_reg(REG_PPU_Q16, ppu);
    write_reg(REG_ORIENT, orient);
    write_reg(REG_FONT_HEIGHT, font);
    cfg_we_i  <= 1'b0;
    cur_minor = (minor == 0) ? 1 : minor;
  endtask

  // Offer one heading beat and return at the edge that accepts it.
  // Valid stays high into the next beat when no gap follows.
  task automatic send_heading(input int unsigned hdg);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    heading_q8_i <= hdg[23:0];
    do @(posedge clk_i); while (!in_ready_o);
    headings_sent++;
  endtask

  // Drop valid and wait until every predicted segment has come out.
  // pending is registered, so the first look comes at the edge after the last accept.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random register set, biased toward tapes that give a useful number of ticks
  task automatic random_tape();
    int unsigned len, minor, minor_eff, major, ppu, pitch;
    len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 300) : $urandom_range(1, 1023);
    case ($urandom_range(0, 9))
      0:       minor = 0;
      1, 2, 3: minor = $urandom_range(1, 36000);
      4, 5:    minor = $urandom_range(1, 200);
      default: minor = 100 * $urandom_range(1, 50);
    endcase
    minor_eff = (minor == 0) ? 1 : minor;
    case ($urandom_range(0, 5))
      0:       major = 0;
      1, 2:    major = $urandom_range(1, 36000);
      3:       major = minor_eff;
      default: major = minor_eff * $urandom_range(2, 6);
    endcase
    if (major > 36000) major = 36000;
    pitch = $urandom_range(1, 48);
    case ($urandom_range(0, 5))
      0:       ppu = $urandom_range(1, 24'hFF_FFFF);
      1:       ppu = $urandom_range(1, 65535);
      default: ppu = (pitch * 65536) / minor_eff + $urandom_range(0, 255);
    endcase
    if (ppu == 0) ppu = 1;
    if (ppu > 24'hFF_FFFF) ppu = 24'hFF_FFFF;
    load_tape($urandom_range(0, 4095), $urandom_range(0, 4095), len, minor, major, ppu,
              $urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  // Mostly uniform over the circle; some land on or next to a minor step edge
  function automatic int unsigned pick_heading();
    int unsigned h, k;
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, HEADING_MAX);
    k = $urandom_range(0, 36000 / cur_minor) * cur_minor;
    case ($urandom_range(0, 4))
      0:       h = k * 256;
      1:       h = k * 256 + 1;
      2:       h = k * 256 + 127;
      3:       h = k * 256 + 128;
      default: h = k * 256 + 255;
    endcase
    if (h > HEADING_MAX) h = HEADING_MAX;
    return h;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: alternates ready stretches and stalls; the long hold-off is counted here
  initial begin
    int left;
    int g;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left > 0) begin
        left--;
      end else if (hold_req) begin
        out_ready_i <= 1'b0;
        left     = HOLD_CYCLES - 1;
        hold_req = 1'b0;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (out_ready_i) begin
        g = idle_len();
        if (g > 0) begin
          out_ready_i <= 1'b0;
          left = g - 1;
        end else begin
          left = $urandom_range(0, 15);
        end
      end else begin
        out_ready_i <= 1'b1;
        left = $urandom_range(0, 15);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned rand_sent;
    int          phase;
    int          n;
    rand_sent = 0;
    phase     = 0;
    repeat (6) @(posedge clk_i);

    // Register defaults straight out of reset: circle ends, half-pixel fraction
    // that rounds up, one just below that rounds to no offset.
    send_heading(0);
    send_heading(HEADING_MAX);
    send_heading(128);
    send_heading(127);
    send_heading(500 * 256 + 255);
    settle();

    // Dense tape: pitch rounds to zero, zero major step, tick count saturates,
    // both origins at their top
    load_tape(4095, 4095, 1023, 1, 0, 1, 1'b0, 0);
    send_heading(0);
    send_heading(HEADING_MAX);
    send_heading(1280 + 77);
    settle();

    // Widest tape with the widest step: start value stays negative after one circle
    load_tape(0, 0, 1023, 36000, 36000, 1, 1'b1, 255);
    send_heading(0);
    send_heading(HEADING_MAX);
    send_heading(4660000);
    settle();

    // Zero minor step with the largest scale factor: big fractional offsets
    load_tape(2000, 100, 600, 0, 1, 24'hFF_FFFF, 1'b0, 17);
    send_heading(0);
    send_heading(255);
    send_heading(HEADING_MAX);
    settle();

    // One-pixel tape: no tick fits, only the index mark comes out
    load_tape(0, 0, 1, 36000, 1000, 65536, 1'b1, 255);
    send_heading(0);
    send_heading(HEADING_MAX);
    send_heading(300);
    settle();

    // Headings near the top of the circle so tick values wrap past it
    load_tape(1000, 3000, 1023, 700, 2100, 3745, 1'b0, 200);
    send_heading(35900 * 256);
    send_heading(HEADING_MAX - 1);
    settle();

    // Random phases, a fresh register set each; phase 1 is the back-pressure one:
    // the sender never idles while the receiver holds off for a long stretch.
    while (rand_sent < RANDOM_HEADINGS) begin
      random_tape();
      quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_req = 1'b1;
      n = $urandom_range(8, 30);
      repeat (n) begin
        send_heading(pick_heading());
        rand_sent++;
      end
      settle();
      quiet = 1'b0;
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    done <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
